// ===== rtl/run_command_field_parser_macros.svh =====
// ----------------------------------------------------------------------------
// RUN command field parser assertion macros
// Shared concurrent assertion forms on the clock and reset of the block.
// ----------------------------------------------------------------------------
`ifndef RUN_COMMAND_FIELD_PARSER_MACROS_SVH
`define RUN_COMMAND_FIELD_PARSER_MACROS_SVH

// Same-cycle implication.
`define RCFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcfp: same-cycle check failed");

// Next-cycle implication.
`define RCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcfp: next-cycle check failed");

`endif

// ===== rtl/rcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// RUN command field parser package
// Types and constants shared by the parser front, the job queue and the
// result emitter.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int unsigned CntW   = 6;
  localparam int unsigned TdataW = 184;

  typedef enum logic [3:0] {
    ST_PREFIX,
    ST_RUN,
    ST_SP1,
    ST_SEL,
    ST_BOOT_FIRST,
    ST_BOOT_ZERO,
    ST_BOOT,
    ST_PHASE,
    ST_DONE
  } stage_e;

  typedef struct packed {
    logic            valid;
    logic [63:0]     run_high;
    logic [63:0]     run_low;
    logic [31:0]     boot;
    logic            phase;
    logic [CntW-1:0] cnt;
    logic            bank;
  } job_t;

  typedef struct packed {
    logic            en;
    logic            bank;
    logic [CntW-1:0] idx;
    logic [7:0]      data;
  } sel_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/rcfp_front.sv =====
// ----------------------------------------------------------------------------
// RUN command parser front
// Accepts one character a cycle while the queue has room, checks it against the
// command form, keeps the parsed fields and posts one job per text at the terminator.
// ----------------------------------------------------------------------------
module rcfp_front #(
  parameter int unsigned SelCapacity = 32,
  localparam int unsigned IdxW = $clog2(SelCapacity)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [7:0]          s_ch_i,
  input  rcfp_pkg::q_status_t q_status_i,
  output logic                push_o,
  output rcfp_pkg::job_t      job_o,
  output rcfp_pkg::sel_wr_t   wr_o
);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChTerm  = 8'h00;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h52;
      2'd1:    c = 8'h55;
      2'd2:    c = 8'h4E;
      default: c = ChSpace;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h66);
  endfunction

  function automatic logic is_sel_char(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           is_digit(c) || (c == 8'h2D) || (c == 8'h2E);
  endfunction

  rcfp_pkg::stage_e stage_q, stage_d;
  logic [4:0]       cc_q, cc_d;
  logic [63:0]      run_hi_q, run_hi_d;
  logic [63:0]      run_lo_q, run_lo_d;
  logic [IdxW-1:0]  selcnt_q, selcnt_d;
  logic [31:0]      boot_q, boot_d;
  logic             phase_q, phase_d;
  logic             failed_q, failed_d;
  logic             bank_q, bank_d;

  logic             accept;
  logic             term;
  logic             fail_hit;
  logic [3:0]       nib;
  logic [3:0]       dig;
  logic [35:0]      prod;

  assign s_ready_o = !q_status_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign term      = (s_ch_i == ChTerm);
  assign dig       = s_ch_i[3:0];
  assign nib       = is_digit(s_ch_i) ? s_ch_i[3:0] : (s_ch_i[3:0] + 4'd9);
  assign prod      = {1'b0, boot_q, 3'b000} + {3'b000, boot_q, 1'b0} + {32'd0, dig};

  always_comb begin
    stage_d  = stage_q;
    fail_hit = 1'b0;
    case (stage_q)
      rcfp_pkg::ST_PREFIX: begin
        if (s_ch_i != prefix_char(cc_q[1:0])) begin
          fail_hit = 1'b1;
        end else if (cc_q[1:0] == 2'd3) begin
          stage_d = rcfp_pkg::ST_RUN;
        end
      end
      rcfp_pkg::ST_RUN: begin
        if (!(is_digit(s_ch_i) || is_lower_hex(s_ch_i))) begin
          fail_hit = 1'b1;
        end else if (cc_q == 5'd31) begin
          stage_d = rcfp_pkg::ST_SP1;
        end
      end
      rcfp_pkg::ST_SP1: begin
        if (s_ch_i != ChSpace) begin
          fail_hit = 1'b1;
        end else begin
          stage_d = rcfp_pkg::ST_SEL;
        end
      end
      rcfp_pkg::ST_SEL: begin
        if (s_ch_i == ChSpace) begin
          if (selcnt_q == '0) begin
            fail_hit = 1'b1;
          end else begin
            stage_d = rcfp_pkg::ST_BOOT_FIRST;
          end
        end else if ((selcnt_q >= IdxW'(SelCapacity - 1)) || !is_sel_char(s_ch_i)) begin
          fail_hit = 1'b1;
        end
      end
      rcfp_pkg::ST_BOOT_FIRST: begin
        if (!is_digit(s_ch_i)) begin
          fail_hit = 1'b1;
        end else if (s_ch_i == ChZero) begin
          stage_d = rcfp_pkg::ST_BOOT_ZERO;
        end else begin
          stage_d = rcfp_pkg::ST_BOOT;
        end
      end
      rcfp_pkg::ST_BOOT_ZERO: begin
        if (s_ch_i != ChSpace) begin
          fail_hit = 1'b1;
        end else begin
          stage_d = rcfp_pkg::ST_PHASE;
        end
      end
      rcfp_pkg::ST_BOOT: begin
        if (s_ch_i == ChSpace) begin
          stage_d = rcfp_pkg::ST_PHASE;
        end else if (!is_digit(s_ch_i) || (prod[35:32] != 4'd0)) begin
          fail_hit = 1'b1;
        end
      end
      rcfp_pkg::ST_PHASE: begin
        if ((s_ch_i != ChZero) && (s_ch_i != ChOne)) begin
          fail_hit = 1'b1;
        end else begin
          stage_d = rcfp_pkg::ST_DONE;
        end
      end
      default: begin
        fail_hit = 1'b1;
      end
    endcase
  end

  always_comb begin
    cc_d       = cc_q;
    run_hi_d   = run_hi_q;
    run_lo_d   = run_lo_q;
    selcnt_d   = selcnt_q;
    boot_d     = boot_q;
    phase_d    = phase_q;
    failed_d   = failed_q;
    bank_d     = bank_q;
    wr_o.en    = 1'b0;
    wr_o.bank  = bank_q;
    wr_o.idx   = rcfp_pkg::CntW'(selcnt_q);
    wr_o.data  = s_ch_i;
    if (accept && term) begin
      cc_d     = '0;
      run_hi_d = '0;
      run_lo_d = '0;
      selcnt_d = '0;
      boot_d   = '0;
      phase_d  = 1'b0;
      failed_d = 1'b0;
      bank_d   = !bank_q;
    end else if (accept && !failed_q) begin
      if (fail_hit) begin
        failed_d = 1'b1;
      end else begin
        case (stage_q)
          rcfp_pkg::ST_PREFIX: begin
            cc_d = (cc_q[1:0] == 2'd3) ? 5'd0 : (cc_q + 5'd1);
          end
          rcfp_pkg::ST_RUN: begin
            if (cc_q[4]) begin
              run_lo_d = {run_lo_q[59:0], nib};
            end else begin
              run_hi_d = {run_hi_q[59:0], nib};
            end
            cc_d = cc_q + 5'd1;
          end
          rcfp_pkg::ST_SEL: begin
            if (s_ch_i != ChSpace) begin
              wr_o.en  = 1'b1;
              selcnt_d = selcnt_q + IdxW'(1);
            end
          end
          rcfp_pkg::ST_BOOT_FIRST: begin
            boot_d = {28'd0, dig};
          end
          rcfp_pkg::ST_BOOT: begin
            if (s_ch_i != ChSpace) begin
              boot_d = prod[31:0];
            end
          end
          rcfp_pkg::ST_PHASE: begin
            phase_d = s_ch_i[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign push_o         = accept && term;
  assign job_o.valid    = !failed_q && (stage_q == rcfp_pkg::ST_DONE) && (selcnt_q != '0);
  assign job_o.run_high = run_hi_q;
  assign job_o.run_low  = run_lo_q;
  assign job_o.boot     = boot_q;
  assign job_o.phase    = phase_q;
  assign job_o.cnt      = rcfp_pkg::CntW'(selcnt_q);
  assign job_o.bank     = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= rcfp_pkg::ST_PREFIX;
      cc_q     <= '0;
      run_hi_q <= '0;
      run_lo_q <= '0;
      selcnt_q <= '0;
      boot_q   <= '0;
      phase_q  <= 1'b0;
      failed_q <= 1'b0;
      bank_q   <= 1'b0;
    end else begin
      if (accept && term) begin
        stage_q <= rcfp_pkg::ST_PREFIX;
      end else if (accept && !failed_q && !fail_hit) begin
        stage_q <= stage_d;
      end
      cc_q     <= cc_d;
      run_hi_q <= run_hi_d;
      run_lo_q <= run_lo_d;
      selcnt_q <= selcnt_d;
      boot_q   <= boot_d;
      phase_q  <= phase_d;
      failed_q <= failed_d;
      bank_q   <= bank_d;
    end
  end

endmodule

// ===== rtl/rcfp_queue.sv =====
// ----------------------------------------------------------------------------
// RUN command job queue
// Two-entry queue of parsed jobs between the parser front and the emitter.
// ----------------------------------------------------------------------------
module rcfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rcfp_pkg::job_t      job_i,
  input  logic                pop_i,
  output rcfp_pkg::job_t      head_o,
  output rcfp_pkg::q_status_t status_o
);

  rcfp_pkg::job_t entry_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign head_o         = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop_i  ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/rcfp_back.sv =====
// ----------------------------------------------------------------------------
// RUN command result emitter
// Holds the two-bank selection memory and turns each queued job into its result
// words, one per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module rcfp_back #(
  parameter int unsigned SelCapacity = 32,
  localparam int unsigned IdxW = $clog2(SelCapacity)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcfp_pkg::sel_wr_t   wr_i,
  input  rcfp_pkg::job_t      head_i,
  input  rcfp_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic                m_valid_res_o,
  output logic [63:0]         m_run_high_o,
  output logic [63:0]         m_run_low_o,
  output logic [31:0]         m_boot_o,
  output logic                m_phase_o,
  output logic [4:0]          m_sel_len_o,
  output logic [4:0]          m_sel_idx_o,
  output logic [7:0]          m_sel_char_o,
  output logic                m_last_o
);

  logic [7:0]      sel_mem_q [2][SelCapacity-1];
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            issue;
  logic            is_last;

  assign issue   = !q_status_i.empty && (!out_valid_q || m_ready_i);
  assign is_last = !head_i.valid ||
                   ((rcfp_pkg::CntW'(idx_q) + rcfp_pkg::CntW'(1)) == head_i.cnt);
  assign pop_o   = issue && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      idx_d       = is_last ? '0 : (idx_q + IdxW'(1));
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      sel_mem_q[wr_i.bank][wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      m_valid_res_o <= head_i.valid;
      m_run_high_o  <= head_i.valid ? head_i.run_high : 64'd0;
      m_run_low_o   <= head_i.valid ? head_i.run_low : 64'd0;
      m_boot_o      <= head_i.valid ? head_i.boot : 32'd0;
      m_phase_o     <= head_i.valid && head_i.phase;
      m_sel_len_o   <= head_i.valid ? head_i.cnt[4:0] : 5'd0;
      m_sel_idx_o   <= head_i.valid ? 5'(idx_q) : 5'd0;
      m_sel_char_o  <= head_i.valid ? sel_mem_q[head_i.bank][idx_q] : 8'd0;
      m_last_o      <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== rtl/run_command_field_parser.sv =====
// ----------------------------------------------------------------------------
// RUN command field parser
// Parses "RUN <32 hex> <selection> <boot> <phase>" text and emits one result
// word per selection character, or one rejection word, at the terminator.
// ----------------------------------------------------------------------------
// The parser takes one character word per cycle while s_axis_tready_o is high.
// A zero character ends the text and posts a job to a two-entry queue; the
// emitter then gives one result word per cycle for that job unless m_axis_tready_i
// stalls it (N words for a selection of N characters, one word for a rejected
// text) through its output register. The selection memory has two banks, so the
// parser keeps accepting the next text while the emitter drains the previous one;
// it holds s_axis_tready_o low only while two finished texts wait in the queue.
module run_command_field_parser #(
  parameter int unsigned SELECTION_CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [7:0] ch
  input  logic [7:0]                  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [63:0] run_high, [127:64] run_low, [159:128] boot, [160] phase,
  // [165:161] selection_length, [170:166] selection_index,
  // [178:171] selection_char, [183:179] zero
  output logic [rcfp_pkg::TdataW-1:0] m_axis_tdata_o,
  // [0] valid_res
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  rcfp_pkg::q_status_t q_status;
  rcfp_pkg::job_t      job_in;
  rcfp_pkg::job_t      job_head;
  rcfp_pkg::sel_wr_t   sel_wr;
  logic                push;
  logic                pop;
  logic [63:0]         run_high;
  logic [63:0]         run_low;
  logic [31:0]         boot;
  logic                phase;
  logic [4:0]          sel_len;
  logic [4:0]          sel_idx;
  logic [7:0]          sel_char;

  rcfp_front #(
    .SelCapacity(SELECTION_CAPACITY)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_ch_i    (s_axis_tdata_i),
    .q_status_i(q_status),
    .push_o    (push),
    .job_o     (job_in),
    .wr_o      (sel_wr)
  );

  rcfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .status_o(q_status)
  );

  rcfp_back #(
    .SelCapacity(SELECTION_CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (sel_wr),
    .head_i       (job_head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_res_o(m_axis_tuser_o),
    .m_run_high_o (run_high),
    .m_run_low_o  (run_low),
    .m_boot_o     (boot),
    .m_phase_o    (phase),
    .m_sel_len_o  (sel_len),
    .m_sel_idx_o  (sel_idx),
    .m_sel_char_o (sel_char),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, sel_char, sel_idx, sel_len, phase, boot, run_low, run_high};

endmodule

// ===== rtl/rcfp_checker.sv =====
// ----------------------------------------------------------------------------
// RUN command field parser port checker
// Watches the result port of the parser over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "run_command_field_parser_macros.svh"

module rcfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_i,
  input logic                        m_axis_tready_i,
  input logic [rcfp_pkg::TdataW-1:0] m_axis_tdata_i,
  input logic                        m_axis_tuser_i,
  input logic                        m_axis_tlast_i
);

  `RCFP_ASSERT_NEXT(a_stall_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i))
  `RCFP_ASSERT_NOW(a_reject_word, m_axis_tvalid_i && !m_axis_tuser_i, m_axis_tlast_i && (m_axis_tdata_i == '0))
  `RCFP_ASSERT_NOW(a_last_index, m_axis_tvalid_i && m_axis_tuser_i && m_axis_tlast_i, (m_axis_tdata_i[170:166] + 5'd1) == m_axis_tdata_i[165:161])
  `RCFP_ASSERT_NEXT(a_run_follow, m_axis_tvalid_i && m_axis_tready_i && !m_axis_tlast_i, m_axis_tvalid_i && m_axis_tuser_i && (m_axis_tdata_i[159:0] == $past(m_axis_tdata_i[159:0])))

endmodule

bind run_command_field_parser rcfp_checker u_rcfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tuser_i (m_axis_tuser_o),
  .m_axis_tlast_i (m_axis_tlast_o)
);
